// File: rtl/core/vmt_pkg.sv
`default_nettype none
package vmt_pkg;

    localparam int NUM_PORTS_DEF = 32;
    localparam int MAX_VID_DEF   = 4094;
    localparam int VID_W         = 12;
    localparam int WORD_W        = 64;
    localparam int WORDS         = 64;
    localparam int WIDX_W        = 6;
    localparam int BIT_W         = 6;

    localparam logic [2:0] REQ_ADD   = 3'd0;
    localparam logic [2:0] REQ_DEL   = 3'd1;
    localparam logic [2:0] REQ_FIND  = 3'd2;
    localparam logic [2:0] REQ_MODE  = 3'd3;
    localparam logic [2:0] REQ_ALLOW = 3'd4;
    localparam logic [2:0] REQ_DENY  = 3'd5;
    localparam logic [2:0] REQ_ADMIT = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_PERM     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] MODE_ACCESS = 2'd0;
    localparam logic [1:0] MODE_TRUNK  = 2'd1;
    localparam logic [1:0] MODE_HYBRID = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [11:0] vid;
        logic [11:0] vid_high;
        logic [4:0]  port;
        logic [1:0]  port_mode;
        logic [11:0] new_pvid;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        admitted;
        logic        vlan_exists;
        logic [11:0] active_count;
    } rsp_t;

    // Mask of bits lo..hi that fall in word w (empty when lo > hi).
    function automatic logic [WORD_W-1:0] range_mask(input logic [WIDX_W-1:0] w,
                                                     input logic [VID_W-1:0] lo,
                                                     input logic [VID_W-1:0] hi);
        logic [WORD_W-1:0] m;
        logic [VID_W-1:0]  v;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            v = {w, b[BIT_W-1:0]};
            m[b] = (v >= lo) && (v <= hi);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/vmt_ram.sv
`default_nettype none
module vmt_ram #(
    parameter int AW = 6
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [vmt_pkg::WORD_W-1:0] wdata,
    input  wire logic [AW-1:0]             raddr,
    output logic      [vmt_pkg::WORD_W-1:0] rdata
);
    logic [vmt_pkg::WORD_W-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/vlan_membership_table_top.sv
`default_nettype none
// channel | ports              | payload
// request | s_valid / s_ready  | s_data  (vmt_pkg::req_t)
// result  | m_valid / m_ready  | m_data  (vmt_pkg::rsp_t)
// Add, delete, find and admits pass S_VRD, S_VWR and S_DONE (S_VWR is skipped when refused
// up front); no new request is taken until the result has been issued.
// Allow, deny and trunk set-mode walk all 64 bitmap words in three steps per word (read,
// data and write back, advance); the first set-mode or allow on a port adds an init sweep of its 64 words.
// After reset a pass over all 64 words clears the active-VLAN memory and sets the VLAN 1 bit;
// no request is taken during it. A held result stalls the following request in S_DONE.
module vlan_membership_table_top #(
    parameter int NUM_PORTS = vmt_pkg::NUM_PORTS_DEF,
    parameter int MAX_VID   = vmt_pkg::MAX_VID_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire vmt_pkg::req_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output vmt_pkg::rsp_t       m_data
);
    localparam int PW  = (NUM_PORTS >= 32) ? 5 : ((NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1);
    localparam int PAW = PW + vmt_pkg::WIDX_W;
    localparam logic [11:0] MAXV = 12'(MAX_VID);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_VRD   = 4'd2;
    localparam logic [3:0] S_VWR   = 4'd3;
    localparam logic [3:0] S_INIT  = 4'd4;
    localparam logic [3:0] S_WRD   = 4'd5;
    localparam logic [3:0] S_WWAIT = 4'd6;
    localparam logic [3:0] S_WWR   = 4'd7;
    localparam logic [3:0] S_PRD   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]  state_reg, state_next;
    vmt_pkg::req_t req_reg, req_next;
    logic [5:0]  widx_reg, widx_next;
    logic [11:0] total_reg, total_next;
    logic [11:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [1:0]  status_reg, status_next;
    logic        exists_reg, exists_next, adm_reg, adm_next;
    logic        mval_reg, mval_next;
    logic [NUM_PORTS-1:0] used_reg, used_next;
    logic [1:0]  mode_reg [NUM_PORTS];
    logic [11:0] pvid_reg [NUM_PORTS];
    vmt_pkg::rsp_t mdata_reg, mdata_next;

    logic        v_we, p_we;
    logic [5:0]  v_waddr, v_raddr;
    logic [63:0] v_wdata, v_rdata, p_wdata, p_rdata;
    logic [PAW-1:0] p_waddr, p_raddr;

    vmt_ram #(.AW(vmt_pkg::WIDX_W)) u_vram (
        .aclk(aclk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata));
    vmt_ram #(.AW(PAW)) u_pram (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata));

    logic [PW-1:0] pidx;
    logic          port_in, vid_ok, trunk;
    logic [5:0]    vbit;
    logic [1:0]    mode_sat;

    assign pidx     = req_reg.port[PW-1:0];
    assign port_in  = {27'd0, req_reg.port} < 32'(NUM_PORTS);
    assign vid_ok   = (req_reg.vid != 12'd0) && (req_reg.vid <= MAXV);
    assign vbit     = req_reg.vid[5:0];
    assign mode_sat = (req_reg.port_mode > vmt_pkg::MODE_HYBRID) ?
                      vmt_pkg::MODE_HYBRID : req_reg.port_mode;
    assign trunk    = (req_reg.req_type == vmt_pkg::REQ_MODE) && (mode_sat == vmt_pkg::MODE_TRUNK);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mval_reg;
    assign m_data  = mdata_reg;

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        widx_next   = widx_reg;
        total_next  = total_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        status_next = status_reg;
        exists_next = exists_reg;
        adm_next    = adm_reg;
        used_next   = used_reg;
        mval_next   = mval_reg;
        mdata_next  = mdata_reg;
        v_we = 1'b0; v_waddr = widx_reg; v_wdata = '0; v_raddr = widx_reg;
        p_we = 1'b0; p_waddr = {pidx, widx_reg}; p_wdata = '0; p_raddr = {pidx, widx_reg};
        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end
        case (state_reg)
            S_CLR: begin
                v_we    = 1'b1;
                v_wdata = (widx_reg == 6'd0) ? 64'd2 : 64'd0;
                widx_next = widx_reg + 6'd1;
                if (widx_reg == 6'd63) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    req_next    = s_data;
                    status_next = vmt_pkg::ST_OK;
                    exists_next = 1'b0;
                    adm_next    = 1'b0;
                    widx_next   = s_data.vid[11:6];
                    state_next  = S_VRD;
                end
            end
            S_VRD: begin
                // read address word issued; classify the request
                v_raddr = req_reg.vid[11:6];
                p_raddr = {pidx, req_reg.vid[11:6]};
                lo_next = (req_reg.vid < 12'd1) ? 12'd1 : req_reg.vid;
                hi_next = (req_reg.vid_high > MAXV) ? MAXV : req_reg.vid_high;
                state_next = S_VWR;
                case (req_reg.req_type)
                    vmt_pkg::REQ_ADD, vmt_pkg::REQ_DEL, vmt_pkg::REQ_FIND: begin
                        if (!vid_ok) begin
                            status_next = vmt_pkg::ST_INVALID;
                            state_next  = S_DONE;
                        end else if (req_reg.req_type == vmt_pkg::REQ_DEL &&
                                     req_reg.vid == 12'd1) begin
                            status_next = vmt_pkg::ST_PERM;
                            state_next  = S_DONE;
                        end
                    end
                    vmt_pkg::REQ_MODE, vmt_pkg::REQ_ALLOW: begin
                        widx_next = 6'd0;
                        if (!port_in) begin
                            status_next = vmt_pkg::ST_PERM;
                            state_next  = S_DONE;
                        end else if (!used_reg[pidx]) begin
                            state_next = S_INIT;
                        end else begin
                            state_next = S_PRD;
                        end
                    end
                    vmt_pkg::REQ_DENY: begin
                        widx_next = 6'd0;
                        if (!port_in || !used_reg[pidx]) begin
                            status_next = vmt_pkg::ST_NOTFOUND;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_WRD;
                        end
                    end
                    vmt_pkg::REQ_ADMIT: begin
                        if (!port_in || !used_reg[pidx]) begin
                            adm_next   = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    default: begin
                        status_next = vmt_pkg::ST_PERM;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_VWR: begin
                // read data for the single-word requests is here
                state_next = S_DONE;
                case (req_reg.req_type)
                    vmt_pkg::REQ_ADD: begin
                        if (!v_rdata[vbit]) begin
                            v_we = 1'b1; v_waddr = req_reg.vid[11:6];
                            v_wdata = v_rdata | (64'd1 << vbit);
                            total_next = total_reg + 12'd1;
                        end
                    end
                    vmt_pkg::REQ_DEL: begin
                        if (!v_rdata[vbit]) begin
                            status_next = vmt_pkg::ST_NOTFOUND;
                        end else begin
                            v_we = 1'b1; v_waddr = req_reg.vid[11:6];
                            v_wdata = v_rdata & ~(64'd1 << vbit);
                            total_next = total_reg - 12'd1;
                        end
                    end
                    vmt_pkg::REQ_FIND: begin
                        if (v_rdata[vbit]) begin
                            exists_next = 1'b1;
                        end else begin
                            status_next = vmt_pkg::ST_NOTFOUND;
                        end
                    end
                    default: begin
                        adm_next = p_rdata[vbit];
                    end
                endcase
            end
            S_INIT: begin
                p_we    = 1'b1;
                p_wdata = (widx_reg == 6'd0) ? 64'd2 : 64'd0;
                widx_next = widx_reg + 6'd1;
                if (widx_reg == 6'd63) begin
                    used_next[pidx] = 1'b1;
                    state_next = S_PRD;
                end
            end
            S_PRD: begin
                // port fields update; then bitmap walk if needed
                widx_next = 6'd0;
                if (req_reg.req_type == vmt_pkg::REQ_MODE && !trunk) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_WRD;
                end
            end
            S_WRD: begin
                state_next = S_WWAIT;
            end
            S_WWAIT: begin
                p_we = 1'b1;
                if (trunk) begin
                    p_wdata = v_rdata;
                end else if (req_reg.req_type == vmt_pkg::REQ_ALLOW) begin
                    p_wdata = p_rdata | vmt_pkg::range_mask(widx_reg, lo_reg, hi_reg);
                end else begin
                    p_wdata = p_rdata & ~vmt_pkg::range_mask(widx_reg, lo_reg, hi_reg);
                end
                state_next = S_WWR;
            end
            S_WWR: begin
                widx_next  = widx_reg + 6'd1;
                state_next = (widx_reg == 6'd63) ? S_DONE : S_WRD;
            end
            S_DONE: begin
                if (!mval_reg) begin
                    mval_next  = 1'b1;
                    mdata_next.status       = status_reg;
                    mdata_next.admitted     = adm_reg;
                    mdata_next.vlan_exists  = exists_reg;
                    mdata_next.active_count = total_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            widx_reg  <= '0;
            total_reg <= 12'd1;
            used_reg  <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            widx_reg  <= widx_next;
            total_reg <= total_next;
            used_reg  <= used_next;
            mval_reg  <= mval_next;
        end
        req_reg    <= req_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        status_reg <= status_next;
        exists_reg <= exists_next;
        adm_reg    <= adm_next;
        mdata_reg  <= mdata_next;
        if (state_reg == S_INIT) begin
            mode_reg[pidx] <= vmt_pkg::MODE_ACCESS;
            pvid_reg[pidx] <= 12'd1;
        end
        if (state_reg == S_PRD && req_reg.req_type == vmt_pkg::REQ_MODE) begin
            mode_reg[pidx] <= mode_sat;
            if ((req_reg.new_pvid != 12'd0) && (req_reg.new_pvid <= MAXV)) begin
                pvid_reg[pidx] <= req_reg.new_pvid;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/vmt_checker.sv
`default_nettype none
module vmt_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire vmt_pkg::req_t s_data,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire vmt_pkg::rsp_t m_data
);
    a_mhold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("request taken twice");
    a_shold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data)) else $error("request changed");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.active_count != 12'd0) else $error("count lost VLAN 1");
endmodule

bind vlan_membership_table_top vmt_checker u_vmt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));
`default_nettype wire
